// ===== sv/arxqr_pkg.sv =====
`default_nettype none

package arxqr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam logic [COUNT_W-1:0] ROUND_COUNT_RST = 8'd32;

  // rotation amounts of one forward round
  localparam int unsigned ROT_A1 = 16;
  localparam int unsigned ROT_C1 = 12;
  localparam int unsigned ROT_A2 = 8;
  localparam int unsigned ROT_C2 = 7;

  // step codes inside one round
  localparam logic [1:0] STEP_0 = 2'd0;
  localparam logic [1:0] STEP_1 = 2'd1;
  localparam logic [1:0] STEP_2 = 2'd2;
  localparam logic [1:0] STEP_3 = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;
  } arxqr_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_a;
    logic [WORD_W-1:0] out_b;
    logic [WORD_W-1:0] out_c;
    logic [WORD_W-1:0] out_d;
  } arxqr_out_t;

  // rotate left by a constant amount
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned s);
    return (x << s) | (x >> (WORD_W - s));
  endfunction

endpackage

`default_nettype wire

// ===== sv/arx_quarter_round_mixer_top.sv =====
`default_nettype none

// channel | ports                          | handshake
// --------+--------------------------------+-----------------------------------
// input   | start, busy, in_req            | request taken when start && !busy
// result  | out_strobe, out_res            | one-cycle strobe, never stalled
// config  | cfg_we, cfg_wdata              | round count written when cfg_we
//
// one add/sub-xor-rotate step per cycle, four steps per quarter round, and round_count
// quarter rounds per item (256 when the count is zero) in the shared step unit;
// the result is registered at the last step and then strobed
// busy drops in the cycle the result strobes, so a new request can be taken
// while the result is shown
// rst_n is synchronous, active low; it restores round_count to 32
// the receiver cannot stall: results are strobed once and not held
module arx_quarter_round_mixer_top
  import arxqr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire arxqr_in_t          in_req,
  output logic                    out_strobe,
  output arxqr_out_t              out_res,
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t              state_r;
  logic [1:0]          step_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic                inv_r;
  logic [WORD_W-1:0]   wa_r, wb_r, wc_r, wd_r;
  logic [COUNT_W-1:0]  round_count_r;
  logic                out_strobe_r;
  arxqr_out_t          out_r;

  // operand selection for the shared step unit
  // pair 0: accumulate d with c, rotate a; pair 1: accumulate b with a, rotate c
  logic              pair_sel;
  logic [WORD_W-1:0] acc_op, src_op, rot_op;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] rot_in;
  logic [WORD_W-1:0] rot_sh;
  logic [WORD_W-1:0] rot_new;
  logic [WORD_W-1:0] wa_nxt, wb_nxt, wc_nxt, wd_nxt;
  logic              last_step;

  // inverse steps run the forward pairs in swapped order
  assign pair_sel = inv_r ? ~step_r[0] : step_r[0];

  always_comb begin
    if (pair_sel) begin
      acc_op = wb_r;
      src_op = wa_r;
      rot_op = wc_r;
    end else begin
      acc_op = wd_r;
      src_op = wc_r;
      rot_op = wa_r;
    end
  end

  // forward: acc += src, rot = rotl(rot ^ acc_new)
  // inverse: rot = rotr(rot) ^ acc_old, acc -= src
  assign sum    = inv_r ? (acc_op - src_op) : (acc_op + src_op);
  assign rot_in = inv_r ? rot_op : (rot_op ^ sum);

  // right rotations are done as left rotations by the complement
  always_comb begin
    case ({inv_r, step_r})
      {1'b0, STEP_0}: rot_sh = rotl(rot_in, ROT_A1);
      {1'b0, STEP_1}: rot_sh = rotl(rot_in, ROT_C1);
      {1'b0, STEP_2}: rot_sh = rotl(rot_in, ROT_A2);
      {1'b0, STEP_3}: rot_sh = rotl(rot_in, ROT_C2);
      {1'b1, STEP_0}: rot_sh = rotl(rot_in, WORD_W - ROT_C2);
      {1'b1, STEP_1}: rot_sh = rotl(rot_in, WORD_W - ROT_A2);
      {1'b1, STEP_2}: rot_sh = rotl(rot_in, WORD_W - ROT_C1);
      {1'b1, STEP_3}: rot_sh = rotl(rot_in, WORD_W - ROT_A1);
      default:        rot_sh = rot_in;
    endcase
  end

  assign rot_new = inv_r ? (rot_sh ^ acc_op) : rot_sh;

  // write back into the words the selected pair owns
  always_comb begin
    wa_nxt = wa_r;
    wb_nxt = wb_r;
    wc_nxt = wc_r;
    wd_nxt = wd_r;
    if (pair_sel) begin
      wb_nxt = sum;
      wc_nxt = rot_new;
    end else begin
      wd_nxt = sum;
      wa_nxt = rot_new;
    end
  end

  // count is tested after each round, so zero runs 256 rounds
  assign last_step = (step_r == STEP_3) && (cnt_r == COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= STEP_0;
      cnt_r         <= '0;
      round_count_r <= ROUND_COUNT_RST;
      out_strobe_r  <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        round_count_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_RUN;
            step_r  <= STEP_0;
            cnt_r   <= round_count_r;
            inv_r   <= in_req.kind;
            wa_r    <= in_req.word_a;
            wb_r    <= in_req.word_b;
            wc_r    <= in_req.word_c;
            wd_r    <= in_req.word_d;
          end
        end
        ST_RUN: begin
          wa_r   <= wa_nxt;
          wb_r   <= wb_nxt;
          wc_r   <= wc_nxt;
          wd_r   <= wd_nxt;
          step_r <= step_r + 2'd1;
          if (step_r == STEP_3) begin
            cnt_r <= cnt_r - COUNT_W'(1);
          end
          if (last_step) begin
            state_r       <= ST_IDLE;
            out_strobe_r  <= 1'b1;
            out_r.out_a   <= wa_nxt;
            out_r.out_b   <= wb_nxt;
            out_r.out_c   <= wc_nxt;
            out_r.out_d   <= wd_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r == ST_RUN);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

  // a request always starts a run
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a run");

  // a run loads the configured count and starts at the first step
  a_run_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> (step_r == STEP_0) && (cnt_r == $past(round_count_r)))
    else $error("run started with wrong step or count");

  // result strobes only when a run has just ended
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result strobe not at end of run");

  // a run cannot end before its last step of a round
  a_no_early_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && (step_r != STEP_3)) |=> busy)
    else $error("run ended mid round");

  // strobes are isolated single cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
